// ----- design/dog_filter_edge_renormalized_unit_macros.svh -----
// assertion macros for the dog filter checker
// expects clk and rst in the scope of each use
`ifndef DOG_FILTER_EDGE_RENORMALIZED_UNIT_MACROS_SVH
`define DOG_FILTER_EDGE_RENORMALIZED_UNIT_MACROS_SVH

// condition now implies a consequence in the next cycle, outside reset
`define DFER_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfer check failed");

// property that holds in the first cycle after reset is released
`define DFER_AFTER_RST(label, cons) \
  label: assert property (@(posedge clk) (!rst && $past(rst)) |-> (cons)) \
    else $error("dfer reset check failed");

`endif

// ----- design/dfer_pkg.sv -----
// shared types, constants and helpers of the dog line filter
// no dependencies
package dfer_pkg;

  localparam int MaxHalf    = 7;
  localparam int WinDepth   = 2 * MaxHalf + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int NumW       = 52;
  localparam int DenW       = 21;
  localparam int DivBits    = 4;
  localparam int DivSteps   = NumW / DivBits;

  localparam logic [2:0] REG_KERNEL_HALF      = 3'd0;
  localparam logic [2:0] REG_NARROW_TAPS_NEAR = 3'd1;
  localparam logic [2:0] REG_NARROW_TAPS_FAR  = 3'd2;
  localparam logic [2:0] REG_WIDE_TAPS_NEAR   = 3'd3;
  localparam logic [2:0] REG_WIDE_TAPS_FAR    = 3'd4;

  typedef struct packed {
    logic [2:0]  half;
    logic [63:0] n_near;
    logic [63:0] n_far;
    logic [63:0] w_near;
    logic [63:0] w_far;
  } cfg_t;

  typedef struct packed {
    logic [WinDepth-1:0][15:0] win;
    logic [3:0]                pos;
    logic                      flush;
    logic [2:0]                d_first;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAC,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_t;

  function automatic logic [15:0] tap_weight(input logic [63:0] near_w,
                                             input logic [63:0] far_w,
                                             input logic [2:0]  k);
    logic [63:0] sel;
    sel = k[2] ? far_w : near_w;
    return sel[{k[1:0], 4'b0000} +: 16];
  endfunction

endpackage

// ----- design/dfer_ifs.sv -----
// valid/ready channel interfaces of the dog line filter
// depends on nothing
interface dfer_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               line_end;
  modport source(output valid, sample, line_end, input ready);
  modport sink(input valid, sample, line_end, output ready);
endinterface

interface dfer_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered;
  logic               final_of_line;
  modport source(output valid, filtered, final_of_line, input ready);
  modport sink(input valid, filtered, final_of_line, output ready);
endinterface

// ----- design/dfer_front.sv -----
// front end: takes samples, keeps the window and line counters, issues jobs
// depends on dfer_pkg and dfer_ifs
module dfer_front
  import dfer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dfer_in_if.sink    samples,
  input  logic [2:0] half,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [WinDepth-1:0][15:0] win, win_next;
  logic [3:0] line_pos, line_pos_next;
  logic [3:0] pending, pending_next;
  logic [3:0] pend_inc, pos_p, hh, cnt;
  logic       take;

  assign samples.ready = !q_full;
  assign take = samples.valid && samples.ready;
  assign hh = {1'b0, half};

  always_comb begin
    win_next      = {win[WinDepth-2:0], samples.sample};
    line_pos_next = (line_pos < 4'd15) ? line_pos + 4'd1 : line_pos;
    pos_p         = line_pos_next - 4'd1;
    pend_inc      = pending + 4'd1;
    cnt           = (pend_inc > hh + 4'd1) ? hh + 4'd1 : pend_inc;
    pending_next  = pend_inc;
    push          = 1'b0;
    push_job.win  = win_next;
    push_job.pos  = pos_p;
    push_job.flush   = samples.line_end;
    push_job.d_first = half;
    if (samples.line_end) begin
      push             = take;
      push_job.d_first = 3'(cnt - 4'd1);
      pending_next     = 4'd0;
      line_pos_next    = 4'd0;
    end else if (pend_inc > hh) begin
      push         = take;
      pending_next = hh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      line_pos <= '0;
      pending  <= '0;
    end else if (take) begin
      win      <= win_next;
      line_pos <= line_pos_next;
      pending  <= pending_next;
    end
  end

endmodule

// ----- design/dfer_queue.sv -----
// short job queue between front and back
// depends on dfer_pkg
module dfer_queue
  import dfer_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;

  assign full       = (count == (QPtrW+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

endmodule

// ----- design/dfer_back.sv -----
// back end: narrow and wide macs stepping over the taps, two 4-bit-a-step dividers, output register
// depends on dfer_pkg and dfer_ifs
module dfer_back
  import dfer_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  dfer_out_if.source results
);

  back_state_t state, state_next;

  logic [WinDepth-1:0][15:0] win;
  logic [3:0]  pos;
  logic        flush;
  logic [2:0]  d;
  logic [3:0]  j;
  logic [3:0]  step;
  logic signed [35:0] nacc, wacc;
  logic [19:0] nsum, wsum;
  logic [NumW-1:0] nq, wq;
  logic [DenW-1:0] nrem, wrem;
  logic        nneg, wneg;

  logic        ovalid;
  logic signed [31:0] ofilt;
  logic        ofinal;

  logic [3:0]  hh, off, dh, s, lo, ipos;
  logic        in_rng, sum_en, last_tap, out_free;
  logic [15:0] tn, tw;
  logic signed [15:0] x;
  logic signed [32:0] prod_n, prod_w;
  logic [34:0] nmag, wmag;
  logic [NumW+DenW-1:0] ndiv, wdiv;
  logic signed [NumW:0]   nterm, wterm;
  logic signed [NumW+1:0] diff;
  logic signed [31:0] sat;

  function automatic logic [NumW+DenW-1:0] div_step(input logic [DenW-1:0] rem,
                                                    input logic [NumW-1:0] num,
                                                    input logic [DenW-1:0] den);
    logic [DenW:0]   r;
    logic [NumW-1:0] q;
    r = {1'b0, rem};
    q = num;
    for (int b = 0; b < DivBits; b++) begin
      r = {r[DenW-1:0], q[NumW-1]};
      q = {q[NumW-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return {r[DenW-1:0], q};
  endfunction

  assign hh       = {1'b0, cfg.half};
  assign off      = (j >= hh) ? j - hh : hh - j;
  assign dh       = {1'b0, d} + hh;
  assign s        = dh - j;
  assign in_rng   = (j <= dh) && (s <= pos);
  assign x        = in_rng ? $signed(win[s]) : 16'sd0;
  assign tn       = tap_weight(cfg.n_near, cfg.n_far, off[2:0]);
  assign tw       = tap_weight(cfg.w_near, cfg.w_far, off[2:0]);
  assign prod_n   = x * $signed({1'b0, tn});
  assign prod_w   = x * $signed({1'b0, tw});
  assign last_tap = (j == {hh[2:0], 1'b0});
  assign out_free = !ovalid || results.ready;

  // edge rule: clipped offsets counted once in the weight sums
  always_comb begin
    ipos = pos - {1'b0, d};
    if (ipos < hh) begin
      lo = ipos + 4'd1;
    end else if (flush && (d < cfg.half)) begin
      lo = {1'b0, d} + 4'd1;
    end else begin
      lo = hh + 4'd1;
    end
  end
  assign sum_en = !((j < hh) && (off >= lo));

  assign nmag  = nacc[35] ? 35'(-nacc) : nacc[34:0];
  assign wmag  = wacc[35] ? 35'(-wacc) : wacc[34:0];
  assign ndiv  = div_step(nrem, nq, {nsum, 1'b0});
  assign wdiv  = div_step(wrem, wq, {wsum, 1'b0});
  assign nterm = (nsum == '0) ? '0 : (nneg ? -$signed({1'b0, nq}) : $signed({1'b0, nq}));
  assign wterm = (wsum == '0) ? '0 : (wneg ? -$signed({1'b0, wq}) : $signed({1'b0, wq}));
  assign diff  = (NumW+2)'(nterm) - (NumW+2)'(wterm);

  always_comb begin
    if (diff > (NumW+2)'(64'sd2147483647)) begin
      sat = 32'sh7fffffff;
    end else if (diff < -(NumW+2)'(64'sd2147483648)) begin
      sat = 32'sh80000000;
    end else begin
      sat = diff[31:0];
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_MAC;
        end
      end
      B_MAC:  if (last_tap) state_next = B_PREP;
      B_PREP: state_next = B_DIV;
      B_DIV:  if (step == 4'(DivSteps - 1)) state_next = B_OUT;
      B_OUT: begin
        if (out_free) begin
          state_next = (flush && (d != 3'd0)) ? B_MAC : B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_OUT && out_free) begin
        ovalid <= 1'b1;
      end else if (results.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        win   <= q_job.win;
        pos   <= q_job.pos;
        flush <= q_job.flush;
        d     <= q_job.d_first;
        j     <= '0;
        nacc  <= '0;
        wacc  <= '0;
        nsum  <= '0;
        wsum  <= '0;
      end
      B_MAC: begin
        j    <= j + 4'd1;
        nacc <= nacc + 36'(prod_n);
        wacc <= wacc + 36'(prod_w);
        if (sum_en) begin
          nsum <= nsum + 20'(tn);
          wsum <= wsum + 20'(tw);
        end
      end
      B_PREP: begin
        nneg <= nacc[35];
        wneg <= wacc[35];
        nq   <= NumW'({nmag, 16'b0}) + NumW'(nsum);
        wq   <= NumW'({wmag, 16'b0}) + NumW'(wsum);
        nrem <= '0;
        wrem <= '0;
        step <= '0;
      end
      B_DIV: begin
        {nrem, nq} <= ndiv;
        {wrem, wq} <= wdiv;
        step       <= step + 4'd1;
      end
      B_OUT: begin
        if (out_free) begin
          ofilt  <= sat;
          ofinal <= flush && (d == 3'd0);
          d      <= d - 3'd1;
          j      <= '0;
          nacc   <= '0;
          wacc   <= '0;
          nsum   <= '0;
          wsum   <= '0;
        end
      end
      default: ;
    endcase
  end

  assign results.valid         = ovalid;
  assign results.filtered      = ofilt;
  assign results.final_of_line = ofinal;

endmodule

// ----- design/dog_filter_edge_renormalized_unit.sv -----
// top level of the difference-of-gaussians line filter with edge renormalization
// depends on dfer_pkg, dfer_ifs, dfer_front, dfer_queue, dfer_back
//
// usage
// - samples: one signed 16-bit sample per transfer, line_end on the last of a line
// - results: signed q16.15 filtered values, final_of_line on the last of a line
// - config: cfg_write with cfg_index/cfg_data, only while the block is idle;
//   indexes beyond the register list are ignored
// - a sample yields one result once half-kernel lookahead is there; line_end
//   flushes up to kernel_half+1 pending results
// - each job is popped from the queue, then per result the two macs step over
//   the 2*kernel_half+1 taps, followed by a setup state, the divider (4 quotient
//   bits per cycle over the 52-bit numerator) and the output state, which waits
//   while the output register is still full; further results of a flush skip the pop
// - samples that cause results pass through a two-entry job queue; the front
//   takes samples as long as the queue has room, so it keeps going while the
//   back works and while a result waits in the output register
// - when results.ready is low the result holds and the back end waits;
//   the queue then fills and samples.ready drops
// - rst (synchronous) clears window, line counters, queue and output valid,
//   and loads the register reset values
module dog_filter_edge_renormalized_unit
  import dfer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dfer_in_if.sink     samples,
  dfer_out_if.source  results,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t cfg;
  logic push, q_full, q_valid, q_pop;
  job_t push_job, head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half   <= 3'd3;
      cfg.n_near <= 64'd65535;
      cfg.n_far  <= '0;
      cfg.w_near <= 64'd65535;
      cfg.w_far  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_HALF:      cfg.half   <= cfg_data[2:0];
        REG_NARROW_TAPS_NEAR: cfg.n_near <= cfg_data;
        REG_NARROW_TAPS_FAR:  cfg.n_far  <= cfg_data;
        REG_WIDE_TAPS_NEAR:   cfg.w_near <= cfg_data;
        REG_WIDE_TAPS_FAR:    cfg.w_far  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample intake, window and line bookkeeping
  dfer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .half     (cfg.half),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples intake from the filter arithmetic
  dfer_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // mac, normalization divide, saturation and output register
  dfer_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

// ----- design/dfer_checker.sv -----
// port-level checks of the dog line filter, bound to the top level
// depends on dog_filter_edge_renormalized_unit_macros.svh
`include "dog_filter_edge_renormalized_unit_macros.svh"

module dfer_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_filtered,
  input logic        out_final
);

  `DFER_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `DFER_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_filtered) && $stable(out_final))
  `DFER_AFTER_RST(a_rst_no_result, !out_valid)
  `DFER_AFTER_RST(a_rst_queue_open, in_ready)

endmodule

bind dog_filter_edge_renormalized_unit dfer_port_checks u_port_checks (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_filtered (results.filtered),
  .out_final    (results.final_of_line)
);

// ----- sim/dfer_checker.sv -----
// scoreboard for the dog line filter: watches config, sample and result transfers,
// predicts each filtered value and compares it with what the block returns
// depends on dfer_pkg and dfer_ifs
module dfer_checker
  import dfer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dfer_in_if          samples,
  dfer_out_if         results,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen
);

  typedef struct {
    logic signed [31:0] filtered;
    logic               fin;
  } dog_result_t;

  dog_result_t expected_q[$];

  logic [2:0]  half_r;
  logic [63:0] n_near_r, n_far_r, w_near_r, w_far_r;
  logic [15:0] window[WinDepth];
  int unsigned line_pos, pend_cnt;

  assign outstanding = expected_q.size();

  function automatic longint unsigned weight_of(logic [63:0] nw, logic [63:0] fw, int k);
    if (k < 4) return nw[16*k +: 16];
    return fw[16*(k-4) +: 16];
  endfunction

  function automatic longint round_term(longint acc, longint unsigned wsum);
    longint unsigned mag, q;
    if (wsum == 0) return 0;
    mag = (acc < 0) ? longint'(-acc) : acc;
    mag = mag << 15;
    q = (2 * mag + wsum) / (2 * wsum);
    return (acc < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] dog_value(int unsigned d, int unsigned h,
                                                   int unsigned p, bit flush);
    int unsigned i, lo, s, off;
    longint unsigned nsum, wsum;
    longint nacc, wacc, res, x;
    i = p - d;
    nacc = 0;
    wacc = 0;
    nsum = weight_of(n_near_r, n_far_r, 0);
    wsum = weight_of(w_near_r, w_far_r, 0);
    for (int k = 1; k <= h; k++) begin
      nsum += 2 * weight_of(n_near_r, n_far_r, k);
      wsum += 2 * weight_of(w_near_r, w_far_r, k);
    end
    // edge renormalization, left edge wins on short lines
    if (i < h) lo = i + 1;
    else if (flush && d < h) lo = d + 1;
    else lo = h + 1;
    for (int k = lo; k <= h; k++) begin
      nsum -= weight_of(n_near_r, n_far_r, k);
      wsum -= weight_of(w_near_r, w_far_r, k);
    end
    for (int j = 0; j <= 2 * h; j++) begin
      if (j > d + h) continue;
      s = d + h - j;
      if (s > p) continue;
      off = (j >= h) ? j - h : h - j;
      x = longint'($signed(window[s % WinDepth]));
      nacc += x * longint'(weight_of(n_near_r, n_far_r, off));
      wacc += x * longint'(weight_of(w_near_r, w_far_r, off));
    end
    res = round_term(nacc, nsum) - round_term(wacc, wsum);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  task automatic take_sample(logic [15:0] smp, logic last);
    int unsigned h, p, cnt;
    dog_result_t r;
    h = half_r;
    for (int s = WinDepth - 1; s > 0; s--) window[s] = window[s-1];
    window[0] = smp;
    if (line_pos < 15) line_pos++;
    pend_cnt++;
    p = line_pos - 1;
    if (!last) begin
      if (pend_cnt > h) begin
        r.filtered = dog_value(h, h, p, 1'b0);
        r.fin = 1'b0;
        expected_q.push_back(r);
        pend_cnt = h;
      end
    end else begin
      // flush everything pending, capped at h+1
      cnt = (pend_cnt > h + 1) ? h + 1 : pend_cnt;
      for (int d = cnt; d > 0; d--) begin
        r.filtered = dog_value(d - 1, h, p, 1'b1);
        r.fin = (d == 1);
        expected_q.push_back(r);
      end
      line_pos = 0;
      pend_cnt = 0;
    end
  endtask

  always @(posedge clk) begin
    dog_result_t e;
    if (rst) begin
      half_r <= 3'd3;
      n_near_r <= 64'd65535;
      n_far_r <= '0;
      w_near_r <= 64'd65535;
      w_far_r <= '0;
      for (int s = 0; s < WinDepth; s++) window[s] = '0;
      line_pos = 0;
      pend_cnt = 0;
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (samples.valid && samples.ready) take_sample(samples.sample, samples.line_end);
      if (results.valid && results.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result filtered=%0d final=%0b", $time,
                   results.filtered, results.final_of_line);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.filtered !== results.filtered || e.fin !== results.final_of_line) begin
            $display("%0t: mismatch expected filtered=%0d final=%0b, got filtered=%0d final=%0b",
                     $time, e.filtered, e.fin, results.filtered, results.final_of_line);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_KERNEL_HALF:      half_r <= cfg_data[2:0];
          REG_NARROW_TAPS_NEAR: n_near_r <= cfg_data;
          REG_NARROW_TAPS_FAR:  n_far_r <= cfg_data;
          REG_WIDE_TAPS_NEAR:   w_near_r <= cfg_data;
          REG_WIDE_TAPS_FAR:    w_far_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// top of the dog line filter testbench: clock, reset, config writes, sample stimulus
// depends on dfer_pkg, dfer_ifs, dfer_checker and the filter top level
module tb_top;
  import dfer_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count, outstanding, results_seen;
  int          idle_pct = 0;   // chance the sender idles in a cycle
  int          stall_pct = 0;  // chance the receiver stalls in a cycle
  int          items_sent = 0;
  int          lines_sent = 0;

  dfer_in_if  samples();
  dfer_out_if results();

  initial begin
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.line_end = 1'b0;
    results.ready = 1'b0;
  end

  always #5 clk = ~clk;

  dog_filter_edge_renormalized_unit u_dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dfer_checker u_checker (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  // one sample transfer, with a random idle gap in front
  task automatic send_sample(logic [15:0] smp, logic last);
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) begin
        samples.valid <= 1'b0;
        @(posedge clk);
      end
    end
    samples.valid <= 1'b1;
    samples.sample <= smp;
    samples.line_end <= last;
    // ready as seen at the edge itself, before the block updates
    @(posedge clk iff samples.ready);
    items_sent++;
    if (last) lines_sent++;
  endtask

  // wait for all expected results, then let the back end settle
  task automatic drain();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_kernel(int h, logic [63:0] nn, logic [63:0] nf,
                             logic [63:0] wn, logic [63:0] wf);
    drain();
    write_reg(REG_KERNEL_HALF, 64'(h));
    write_reg(REG_NARROW_TAPS_NEAR, nn);
    write_reg(REG_NARROW_TAPS_FAR, nf);
    write_reg(REG_WIDE_TAPS_NEAR, wn);
    write_reg(REG_WIDE_TAPS_FAR, wf);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_taps();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_line(int len);
    for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1);
  endtask

  initial begin
    int budget;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset kernel, single-sample line, extremes, short lines
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_line(3);
    send_line(8);
    // widest kernel with a line long enough to saturate the position count
    load_kernel(7, '1, '1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008);
    send_line(2);
    for (int k = 0; k < 18; k++) send_sample(k[0] ? 16'h7fff : 16'h8000, k == 17);
    // zero weight sums make both terms zero; one-tap kernel
    load_kernel(0, '0, '0, '0, '0);
    send_line(3);
    load_kernel(1, 64'hffff, '0, 64'h0000_0000_ffff_0001, 64'hffff_ffff_ffff_ffff);
    send_line(4);
    // indexes past the register list are ignored
    drain();
    write_reg(3'd5, '1);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    send_line(5);

    // random phases: free running, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 70 : (ph == 3) ? 38 : 0;
      stall_pct = (ph == 2) ? 70 : (ph == 3) ? 38 : 0;
      budget = items_sent + 78;
      while (items_sent < budget) begin
        if ($urandom_range(3) == 0)
          load_kernel((($urandom_range(4) == 0) ? 7 : $urandom_range(1, 7)),
                      rand_taps(), rand_taps(), rand_taps(), rand_taps());
        send_line(($urandom_range(5) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 10));
      end
    end

    drain();
    $display("sent %0d samples in %0d lines, checked %0d results over half widths 0..7",
             items_sent, lines_sent, results_seen);
    $display("phases: directed edge cases, then random kernels with idle and stall mixes");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
